### rtl/armp_pkg.sv
// Shared constants and types for the audio resample / mu-law packetizer.
// No dependencies; imported by every module of the block.
package armp_pkg;

    // Sizes fixed by the transaction fields
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned RATE_W   = 18;
    localparam int unsigned PHASE_W  = 18;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned TS_W     = 32;
    localparam int unsigned POS_W    = 8;

    // Resampler and packet framing
    localparam int unsigned OUTPUT_RATE    = 8000;
    localparam int unsigned PACKET_SAMPLES = 160;
    localparam int unsigned RATE_MIN       = 2000;
    localparam int unsigned RATE_MAX       = 192000;
    localparam int unsigned RATE_RESET     = 48000;
    localparam int unsigned MAX_OUT        = 4;

    // Worst-case output samples one frame can call for, and the sum width
    // needed to form phase + k * rate for every such k without wrapping.
    localparam int unsigned MAX_STEPS  = (OUTPUT_RATE + RATE_MIN - 1) / RATE_MIN;
    localparam int unsigned STEP_CNT_W = $clog2(MAX_STEPS + 1);
    localparam int unsigned OUT_CNT_W  = $clog2(MAX_OUT + 1);
    localparam int unsigned SUM_W      = $clog2(RATE_MAX * (MAX_STEPS + 1) + 1);

    // G.711 mu-law
    localparam int signed   MU_CLIP = 32635;
    localparam int unsigned MU_BIAS = 'h84;

    // Configuration register map
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 18;
    localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_RATE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MONO_INPUT = 1'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CODE_W-1:0]          code_t;

endpackage

### rtl/armp_mulaw_enc.sv
// G.711 mu-law encoder: clip, bias, segment search, inverted byte.
// Depends on armp_pkg.
module armp_mulaw_enc
    import armp_pkg::*;
(
    input  sample_t pcm,
    output code_t   code
);

    sample_t     clipped;
    logic        sign;
    logic [14:0] mag;
    logic [2:0]  exp_val;
    logic [14:0] shifted;

    always_comb begin
        if (pcm > SAMPLE_W'(MU_CLIP)) begin
            clipped = SAMPLE_W'(MU_CLIP);
        end else if (pcm < -SAMPLE_W'(MU_CLIP)) begin
            clipped = -SAMPLE_W'(MU_CLIP);
        end else begin
            clipped = pcm;
        end
        sign = clipped[SAMPLE_W-1];
        mag  = (sign ? 15'(-clipped) : 15'(clipped)) + 15'(MU_BIAS);

        // Highest set bit among 14..8 picks the segment
        exp_val = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (mag[i+7]) begin
                exp_val = 3'(i);
            end
        end
        shifted = mag >> (4'(exp_val) + 4'd3);
        code    = ~{sign, exp_val, shifted[3:0]};
    end

endmodule

### rtl/audio_resample_mulaw_packetizer.sv
// 8 kHz resampler, G.711 mu-law encoder and packetizer; uses armp_pkg and armp_mulaw_enc.
// An accepted frame is registered in the job slot; each of its bytes is then encoded into the output register.
// Throughput: one frame per cycle while each frame yields at most one byte and the output is not
// stalled; a frame that yields k bytes (up to 4) holds the job slot until all k have been emitted.
// Reset (aresetn low, synchronous): clears phase, packet fill, timestamp and
// all valids; input_rate returns to 48000, mono_input to 0.
module audio_resample_mulaw_packetizer
    import armp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Input frames
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_t               s_left_sample,
    input  sample_t               s_right_sample,

    // Output bytes
    output logic                  m_valid,
    input  logic                  m_ready,
    output code_t                 m_mulaw_code,
    output logic [TS_W-1:0]       m_packet_timestamp,
    output logic [POS_W-1:0]      m_position_in_packet,
    output logic                  m_last_in_packet
);

    // ------------------------------------------------------------------
    // Configuration registers. The rate is saturated on the way in, so the
    // stored value is always within the supported range.
    // ------------------------------------------------------------------
    logic [RATE_W-1:0] input_rate_reg;
    logic              mono_input_reg;
    logic [RATE_W-1:0] rate_sat;

    always_comb begin
        if (cfg_wdata < RATE_W'(RATE_MIN)) begin
            rate_sat = RATE_W'(RATE_MIN);
        end else if (cfg_wdata > RATE_W'(RATE_MAX)) begin
            rate_sat = RATE_W'(RATE_MAX);
        end else begin
            rate_sat = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_rate_reg <= RATE_W'(RATE_RESET);
            mono_input_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_INPUT_RATE: input_rate_reg <= rate_sat;
                CFG_MONO_INPUT: mono_input_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake control.
    // job_*  : one accepted frame waiting to emit its bytes
    // out_free: the output register can take a byte this cycle
    // ------------------------------------------------------------------
    logic                 job_valid_reg;
    logic [OUT_CNT_W-1:0] job_cnt_reg;
    sample_t              job_sample_reg;
    logic                 m_valid_reg;

    logic out_free;
    logic emit;
    logic job_done;
    logic in_acc;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = job_valid_reg && out_free;
    assign job_done = emit && (job_cnt_reg == OUT_CNT_W'(1));
    // Take a new frame when the job slot is empty or empties this cycle
    assign s_ready  = !job_valid_reg || job_done;
    assign in_acc   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Channel mix: average rounds toward zero; mono uses left alone.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W:0] ch_sum;
    logic signed [SAMPLE_W:0] ch_sum_adj;
    sample_t                  mix_sample;

    always_comb begin
        ch_sum     = {s_left_sample[SAMPLE_W-1], s_left_sample}
                   + {s_right_sample[SAMPLE_W-1], s_right_sample};
        ch_sum_adj = ch_sum + (SAMPLE_W+1)'(ch_sum[SAMPLE_W]);
        mix_sample = mono_input_reg ? s_left_sample : ch_sum_adj[SAMPLE_W:1];
    end

    // ------------------------------------------------------------------
    // Phase accumulator. Count the output ticks that fall inside this
    // frame (phase + k * rate below OUTPUT_RATE), then advance by that
    // many rates and drop one frame length.
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]    phase_reg;
    logic [SUM_W-1:0]      phase_ext;
    logic [SUM_W-1:0]      rate_ext;
    logic [SUM_W-1:0]      phase_adv;
    logic [STEP_CNT_W-1:0] step_cnt;
    logic [OUT_CNT_W-1:0]  emit_cnt;
    logic [PHASE_W-1:0]    phase_new;

    always_comb begin
        phase_ext = SUM_W'(phase_reg);
        rate_ext  = SUM_W'(input_rate_reg);
        step_cnt  = '0;
        for (int k = 0; k < MAX_STEPS; k++) begin
            if (phase_ext + SUM_W'(k) * rate_ext < SUM_W'(OUTPUT_RATE)) begin
                step_cnt = step_cnt + STEP_CNT_W'(1);
            end
        end
        phase_adv = phase_ext + SUM_W'(step_cnt) * rate_ext - SUM_W'(OUTPUT_RATE);
        phase_new = phase_adv[PHASE_W-1:0];
        // Beyond MAX_OUT ticks the phase still advances but bytes are dropped
        if (int'(step_cnt) > MAX_OUT) begin
            emit_cnt = OUT_CNT_W'(MAX_OUT);
        end else begin
            emit_cnt = OUT_CNT_W'(step_cnt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (in_acc) begin
            phase_reg <= phase_new;
        end
    end

    // ------------------------------------------------------------------
    // Job slot: hold the mixed sample and the number of bytes still owed.
    // Frames with no output tick only move the phase.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            job_cnt_reg   <= '0;
        end else if (in_acc && emit_cnt != '0) begin
            job_valid_reg <= 1'b1;
            job_cnt_reg   <= emit_cnt;
        end else if (job_done) begin
            job_valid_reg <= 1'b0;
        end else if (emit) begin
            job_cnt_reg <= job_cnt_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            job_sample_reg <= mix_sample;
        end
    end

    // ------------------------------------------------------------------
    // Encoder and packet framing feed the output register.
    // ------------------------------------------------------------------
    code_t             enc_code;
    logic [POS_W-1:0]  fill_reg;
    logic [TS_W-1:0]   ts_reg;
    logic              last_w;
    code_t             code_reg;
    logic [TS_W-1:0]   out_ts_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_last_reg;

    armp_mulaw_enc u_enc (
        .pcm  (job_sample_reg),
        .code (enc_code)
    );

    // A byte whose fill plus one reaches or passes the packet length closes the packet
    assign last_w = (int'(fill_reg) + 1) >= PACKET_SAMPLES;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ts_reg   <= '0;
        end else if (emit) begin
            if (last_w) begin
                fill_reg <= '0;
                ts_reg   <= ts_reg + TS_W'(PACKET_SAMPLES);
            end else begin
                fill_reg <= fill_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            code_reg     <= enc_code;
            out_ts_reg   <= ts_reg;
            out_pos_reg  <= fill_reg;
            out_last_reg <= last_w;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_mulaw_code         = code_reg;
    assign m_packet_timestamp   = out_ts_reg;
    assign m_position_in_packet = out_pos_reg;
    assign m_last_in_packet     = out_last_reg;

endmodule

### rtl/armp_checker.sv
// Port-level checks for the packetizer, bound to the top level.
// Depends on armp_pkg and audio_resample_mulaw_packetizer.
module armp_checker
    import armp_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input code_t            m_mulaw_code,
    input logic [TS_W-1:0]  m_packet_timestamp,
    input logic [POS_W-1:0] m_position_in_packet,
    input logic             m_last_in_packet
);

    // Reset leaves no byte pending
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Byte index stays inside the packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_position_in_packet) < PACKET_SAMPLES))
        else $error("position beyond packet length");

    // Last flag marks exactly the final index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_in_packet
                     == (int'(m_position_in_packet) == PACKET_SAMPLES - 1)))
        else $error("last flag does not match position");

    // Stalled output transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mulaw_code)
            && $stable(m_packet_timestamp) && $stable(m_position_in_packet))
        else $error("stalled output changed");

endmodule

bind audio_resample_mulaw_packetizer armp_checker u_armp_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_mulaw_code         (m_mulaw_code),
    .m_packet_timestamp   (m_packet_timestamp),
    .m_position_in_packet (m_position_in_packet),
    .m_last_in_packet     (m_last_in_packet)
);

### tb/sv/armp_byte_checker.sv
`timescale 1ns / 100ps
// Byte checker for the audio resample / mu-law packetizer: watches the register,
// frame and byte ports, predicts each byte and compares it. Depends on armp_pkg.
module armp_byte_checker
    import armp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  sample_t               s_left_sample,
    input  sample_t               s_right_sample,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  code_t                 m_mulaw_code,
    input  logic [TS_W-1:0]       m_packet_timestamp,
    input  logic [POS_W-1:0]      m_position_in_packet,
    input  logic                  m_last_in_packet,
    output int                    mismatch_count,
    output int                    bytes_outstanding
);

    typedef struct {
        code_t            code;
        logic [TS_W-1:0]  stamp;
        logic [POS_W-1:0] position;
        logic             last;
    } mulaw_byte_t;

    localparam int OUT_RATE   = OUTPUT_RATE;
    localparam int PKT_LEN    = PACKET_SAMPLES;
    localparam int PHASE_MASK = (1 << PHASE_W) - 1;

    mulaw_byte_t       bytes_due[$];
    logic [RATE_W-1:0] rate_reg;
    logic              mono_reg;
    int                phase;
    int                fill;
    logic [TS_W-1:0]   stamp;
    int                errors = 0;

    // Clip, bias, find the segment, then invert sign/exponent/mantissa.
    function automatic code_t mulaw_encode(input int pcm);
        logic [7:0] sign;
        int         mag;
        int         seg;
        sign = 8'h00;
        if (pcm > MU_CLIP) pcm = MU_CLIP;
        if (pcm < -MU_CLIP) pcm = -MU_CLIP;
        if (pcm < 0) begin
            sign = 8'h80;
            mag  = -pcm;
        end else begin
            mag = pcm;
        end
        mag = mag + int'(MU_BIAS);
        seg = 7;
        while (seg > 0 && mag[seg + 7] == 1'b0) seg--;
        return ~(sign | 8'(seg << 4) | 8'((mag >> (seg + 3)) & 'hF));
    endfunction

    // Average the channels, advance the phase and queue the bytes this frame yields.
    task automatic resample_frame(input sample_t l, input sample_t r);
        int          left_v;
        int          right_v;
        int          rate;
        int          n;
        code_t       code;
        mulaw_byte_t b;
        left_v  = l;
        right_v = mono_reg ? left_v : int'(r);
        code    = mulaw_encode((left_v + right_v) / 2);
        rate    = int'(rate_reg);
        if (rate < int'(RATE_MIN)) rate = int'(RATE_MIN);
        if (rate > int'(RATE_MAX)) rate = int'(RATE_MAX);
        n = 0;
        while (phase < OUT_RATE) begin
            phase = phase + rate;
            if (n < MAX_OUT) begin
                b.code     = code;
                b.stamp    = stamp;
                b.position = POS_W'(fill);
                b.last     = (fill + 1 >= PKT_LEN);
                bytes_due.insert(bytes_due.size(), b);
                if (b.last) begin
                    fill  = 0;
                    stamp = stamp + TS_W'(PKT_LEN);
                end else begin
                    fill = (fill + 1) & 'hFF;
                end
                n++;
            end
        end
        phase = (phase - OUT_RATE) & PHASE_MASK;
    endtask

    task automatic take_byte();
        mulaw_byte_t b;
        if (bytes_due.size() == 0) begin
            $error("unexpected byte: mulaw_code %02h position_in_packet %0d",
                   m_mulaw_code, m_position_in_packet);
            errors++;
        end else begin
            b = bytes_due[0];
            bytes_due.delete(0);
            if (m_mulaw_code !== b.code) begin
                $error("mulaw_code: expected %02h, actual %02h", b.code, m_mulaw_code);
                errors++;
            end
            if (m_packet_timestamp !== b.stamp) begin
                $error("packet_timestamp: expected %0d, actual %0d",
                       b.stamp, m_packet_timestamp);
                errors++;
            end
            if (m_position_in_packet !== b.position) begin
                $error("position_in_packet: expected %0d, actual %0d",
                       b.position, m_position_in_packet);
                errors++;
            end
            if (m_last_in_packet !== b.last) begin
                $error("last_in_packet: expected %0b, actual %0b", b.last, m_last_in_packet);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg = RATE_W'(RATE_RESET);
            mono_reg = 1'b0;
            phase    = 0;
            fill     = 0;
            stamp    = '0;
            bytes_due.delete();
        end else begin
            // Bytes leaving now come from older frames: retire them first.
            if (m_valid && m_ready) take_byte();
            if (s_valid && s_ready) resample_frame(s_left_sample, s_right_sample);
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_INPUT_RATE: rate_reg = cfg_wdata[RATE_W-1:0];
                    CFG_MONO_INPUT: mono_reg = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        mismatch_count    <= errors;
        bytes_outstanding <= bytes_due.size();
    end

endmodule

### tb/sv/audio_resample_mulaw_packetizer_test.sv
`timescale 1ns / 100ps
// Top of the packetizer test: clock, reset, register writes, frame stimulus and
// byte back-pressure. Depends on armp_pkg, the block and armp_byte_checker.
module audio_resample_mulaw_packetizer_test
    import armp_pkg::*;
;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    localparam int STALL_LIMIT     = 1000;  // cycles without any transaction
    localparam int DRAIN_CYCLES    = 8;     // settle time after the last predicted byte; leave margin
    localparam int DEFAULT_FRAMES  = 6;
    localparam int DIRECTED_FRAMES = 18;
    localparam int STEREO_FRAMES   = 15;    // directed frames before mono is set
    localparam int RANDOM_PHASES   = 7;
    localparam int FRAMES_PER_PHASE = 12;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    sample_t               s_left_sample;
    sample_t               s_right_sample;
    logic                  m_valid;
    logic                  m_ready;
    code_t                 m_mulaw_code;
    logic [TS_W-1:0]       m_packet_timestamp;
    logic [POS_W-1:0]      m_position_in_packet;
    logic                  m_last_in_packet;
    int                    mismatch_count;
    int                    bytes_outstanding;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    // Directed frames: full scale, zero, rounding toward zero on odd sums,
    // the clip threshold on both sides, a segment boundary and tiny values.
    // The last three run in mono mode, where the right channel must be ignored.
    int dir_left [DIRECTED_FRAMES] = '{32767, 0, -1, -1, 1, -3, 32767, 32635, 32636,
                                       -32635, -32636, 16250, 16252, 31, -32,
                                       100, -32768, 32767};
    int dir_right[DIRECTED_FRAMES] = '{32767, 0, -1, 0, 0, 0, -32768, 32635, 32636,
                                       -32635, -32636, 16250, 16252, 31, -32,
                                       -32768, 32767, -1};

    // Rates for the random phases: slowest, saturation from below and above,
    // fastest, just under the floor, and a common audio rate. The last phase
    // draws its rate at random.
    logic [RATE_W-1:0] fixed_rates[RANDOM_PHASES-1] = '{RATE_W'(2000), RATE_W'(0),
                                                        RATE_W'(192000), RATE_W'(262143),
                                                        RATE_W'(1999), RATE_W'(11025)};

    audio_resample_mulaw_packetizer u_top (.*);

    armp_byte_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure: draw ready anew at every falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct    = 45;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 45;
            end
            default: begin
                sender_idle_pct    = 14;
                receiver_stall_pct = 14;
            end
        endcase
    endtask

    // Mostly full-range values; some extremes and some values near zero.
    function automatic sample_t random_sample();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(5))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    4: return sample_t'(MU_CLIP + 1);
                    default: return sample_t'(-MU_CLIP - 1);
                endcase
            end
            1: return sample_t'(int'($urandom_range(511)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Enter and leave at a falling edge. Idle first, then hold the frame
    // until the block takes it.
    task automatic send_frame(input sample_t l, input sample_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_left_sample  <= l;
        s_right_sample <= r;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Single-cycle register write, entered at a falling edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Drop valid, wait for every predicted byte, then let the pipeline settle
    // since a frame may yield no byte at all.
    task automatic drain();
        s_valid <= 1'b0;
        while (bytes_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [RATE_W-1:0] rate;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = CFG_INPUT_RATE;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_left_sample  = '0;
        s_right_sample = '0;
        m_ready        = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values: 48 kHz stereo, so only the first of six frames yields a byte.
        for (int i = 0; i < DEFAULT_FRAMES; i++) begin
            send_frame(i == 0 ? sample_t'(16'sh8000) : random_sample(), random_sample());
        end
        drain();

        // Directed values at 8 kHz, one byte per frame.
        write_reg(CFG_INPUT_RATE, CFG_DATA_W'(OUTPUT_RATE));
        for (int i = 0; i < DIRECTED_FRAMES; i++) begin
            if (i == STEREO_FRAMES) begin
                drain();
                write_reg(CFG_MONO_INPUT, CFG_DATA_W'(1));
            end
            send_frame(sample_t'(dir_left[i]), sample_t'(dir_right[i]));
        end
        drain();

        // Random phases: new rate and channel mode each time, idling rotates.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < RANDOM_PHASES - 1) begin
                rate = fixed_rates[p];
            end else begin
                rate = RATE_W'($urandom_range(RATE_MAX, RATE_MIN));
            end
            write_reg(CFG_INPUT_RATE, rate);
            write_reg(CFG_MONO_INPUT, CFG_DATA_W'(p % 2));
            set_idling(idling_t'(p % 4));
            for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
                send_frame(random_sample(), random_sample());
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/armp_pkg.sv
rtl/armp_mulaw_enc.sv
rtl/audio_resample_mulaw_packetizer.sv
rtl/armp_checker.sv
tb/sv/armp_byte_checker.sv
tb/sv/audio_resample_mulaw_packetizer_test.sv
